/* hdl/implode_pkg.sv */
`timescale 1ns / 1ps

package implode_pkg;

  localparam int HIST_AW = 12;
  localparam int POS_W = 5;
  localparam int CNT_OUT_W = 24;
  localparam logic [9:0] END_LEN = 10'd519;
  localparam logic [CNT_OUT_W-1:0] COUNT_MAX = 24'hFFFFFF;

  localparam logic [2:0] ST_RUN = 3'd0;
  localparam logic [2:0] ST_OK = 3'd1;
  localparam logic [2:0] ST_BAD_MODE = 3'd2;
  localparam logic [2:0] ST_BAD_DICT = 3'd3;
  localparam logic [2:0] ST_OVERRUN = 3'd4;
  localparam logic [2:0] ST_BAD_DIST = 3'd5;
  localparam logic [2:0] ST_SIZE = 3'd6;

  localparam logic CFG_FIXED = 1'b0;
  localparam logic CFG_TARGET = 1'b1;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_OFFER = 16'h0002,
    S_HDR0  = 16'h0004,
    S_HDR1  = 16'h0008,
    S_DISP  = 16'h0010,
    S_FLAG  = 16'h0020,
    S_LITW  = 16'h0040,
    S_LIT   = 16'h0080,
    S_LENW  = 16'h0100,
    S_LENX  = 16'h0200,
    S_DSTW  = 16'h0400,
    S_DSTX  = 16'h0800,
    S_CHK   = 16'h1000,
    S_CRD   = 16'h2000,
    S_CEM   = 16'h4000,
    S_RESP  = 16'h8000
  } state_t;

  typedef enum logic [1:0] {
    TR_LIT = 2'd0,
    TR_LEN = 2'd1,
    TR_DST = 2'd2
  } tree_t;

  typedef struct packed {
    state_t op;
    logic   start;
  } cmd_t;

  typedef struct packed {
    logic [1:0] hphase;
    logic       byte_ok;
    logic       hdr_bad;
    logic       copy_pending;
    logic       size_reached;
    logic       flag_bit;
    logic       ascii;
    logic       leaf;
    logic       is_end;
    logic       bits_ok;
    logic       overrun;
    logic       bad_dist;
    logic       stopped;
    logic       out_free;
  } sts_t;

  localparam logic [7:0] LEN_BR [16] = '{1, 2, 3, 3, 3, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};
  localparam logic [7:0] DST_BR [16] = '{1, 2, 3, 6, 10, 16, 17, 8, 0, 0, 0, 0, 0, 0, 0, 0};
  localparam logic [7:0] LIT_BR [16] = '{1, 2, 4, 8, 15, 19, 18, 15, 14, 21, 37, 64, 37, 0,
                                         0, 0};

  localparam logic [7:0] LEN_SYM [16] = '{1, 3, 2, 0, 6, 5, 4, 10, 9, 8, 7, 13, 12, 11, 15, 14};

  localparam logic [7:0] DST_SYM [64] = '{
    0, 2, 1, 6, 5, 4, 3,
    21, 20, 19, 18, 17, 16, 15, 14, 13, 12, 11, 10, 9, 8, 7,
    47, 46, 45, 44, 43, 42, 41, 40, 39, 38, 37, 36, 35, 34, 33, 32,
    31, 30, 29, 28, 27, 26, 25, 24, 23, 22,
    63, 62, 61, 60, 59, 58, 57, 56, 55, 54, 53, 52, 51, 50, 49, 48};

  localparam logic [7:0] LIT_SYM [256] = '{
    32,
    117, 116, 115, 114, 111, 110, 108, 105, 101, 97, 69,
    112, 109, 104, 103, 102, 100, 99, 98, 84, 83, 82, 79, 78, 76, 73, 68, 67, 65, 49, 45,
    119, 107, 85, 80, 77, 70, 66, 61, 56, 55, 53, 52, 51, 50, 48, 46, 44, 41, 40, 13, 10,
    121, 120, 118, 95, 91, 87, 72, 71, 58, 57, 54, 47, 42, 39, 34, 9,
    93, 89, 88, 86, 75, 62, 43,
    122, 113, 38, 36, 33,
    124, 123, 106, 92, 90, 81, 74, 63, 60, 0,
    244, 243, 242, 238, 233, 229, 225, 223, 222, 221, 220, 219, 218, 217, 216, 215,
    214, 213, 212, 211, 210, 209, 208, 207, 206, 205, 204, 203, 202, 201, 200, 199,
    198, 197, 196, 195, 194, 193, 192, 191, 190, 189, 188, 187, 186, 185, 184, 183,
    182, 181, 180, 179, 178, 177, 176, 127, 126, 125, 96, 94, 64, 59, 37, 35,
    31, 30, 29, 28, 27, 25, 24, 23, 22, 21, 20, 19, 18, 17, 16, 15,
    14, 12, 11, 8, 7, 6, 5, 4, 3, 2, 1,
    255, 254, 253, 252, 251, 250, 249, 248, 247, 246, 245, 241, 240, 239, 237, 236,
    235, 234, 232, 231, 230, 228, 227, 226, 224, 175, 174, 173, 172, 171, 170, 169,
    168, 167, 166, 165, 164, 163, 162, 161, 160, 159, 158, 157, 156, 155, 154, 153,
    152, 151, 150, 149, 148, 147, 146, 145, 144, 143, 142, 141, 140, 139, 138, 137,
    136, 135, 134, 133, 132, 131, 130, 129, 128, 26};

  function automatic logic [7:0] tree_branch(tree_t t, logic [3:0] lvl);
    logic [7:0] r;
    r = '0;
    case (t)
      TR_LIT: r = LIT_BR[lvl];
      TR_LEN: r = LEN_BR[lvl];
      TR_DST: r = DST_BR[lvl];
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] tree_symbol(tree_t t, logic [7:0] idx);
    logic [7:0] r;
    r = '0;
    case (t)
      TR_LIT: r = LIT_SYM[idx];
      TR_LEN: r = LEN_SYM[idx[3:0]];
      TR_DST: r = DST_SYM[idx[5:0]];
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/implode_ctrl.sv */
`timescale 1ns / 1ps

module implode_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_req_type,
  output logic                in_ready,
  input  implode_pkg::sts_t   sts,
  output implode_pkg::cmd_t   cmd
);
  import implode_pkg::*;

  state_t state_r, state_nxt;
  logic   start;

  assign in_ready  = (state_r == S_IDLE);
  assign start     = in_valid && in_ready;
  assign cmd.op    = state_r;
  assign cmd.start = start;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (!in_req_type) state_nxt = S_OFFER;
          else if (sts.stopped) state_nxt = S_RESP;
          else state_nxt = S_HDR0;
        end
      end
      S_OFFER: state_nxt = S_RESP;
      S_HDR0: begin
        if (sts.hphase != 2'd0) state_nxt = S_HDR1;
        else if (!sts.byte_ok || sts.hdr_bad) state_nxt = S_RESP;
        else state_nxt = S_HDR1;
      end
      S_HDR1: begin
        if (sts.hphase != 2'd1) state_nxt = S_DISP;
        else if (!sts.byte_ok || sts.hdr_bad) state_nxt = S_RESP;
        else state_nxt = S_DISP;
      end
      S_DISP: begin
        if (sts.copy_pending) state_nxt = S_CRD;
        else if (sts.size_reached) state_nxt = S_RESP;
        else state_nxt = S_FLAG;
      end
      S_FLAG: begin
        if (sts.flag_bit) state_nxt = S_LENW;
        else if (sts.ascii) state_nxt = S_LITW;
        else state_nxt = S_LIT;
      end
      S_LITW: if (sts.leaf) state_nxt = S_LIT;
      S_LIT: state_nxt = S_RESP;
      S_LENW: if (sts.leaf) state_nxt = S_LENX;
      S_LENX: state_nxt = sts.is_end ? S_RESP : S_DSTW;
      S_DSTW: if (sts.leaf) state_nxt = S_DSTX;
      S_DSTX: state_nxt = S_CHK;
      S_CHK: begin
        if (!sts.bits_ok || sts.overrun || sts.bad_dist) state_nxt = S_RESP;
        else state_nxt = S_CRD;
      end
      S_CRD: state_nxt = S_CEM;
      S_CEM: state_nxt = S_RESP;
      S_RESP: if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/implode_dp.sv */
`timescale 1ns / 1ps

module implode_dp #(
  parameter int BB = 40
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_idx,
  input  logic [23:0]         cfg_wdata,
  input  logic [7:0]          in_in_byte,
  input  logic                in_in_last,
  input  implode_pkg::cmd_t   cmd,
  output implode_pkg::sts_t   sts,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_byte_taken,
  output logic                out_room_for_byte,
  output logic                out_out_valid,
  output logic [7:0]          out_out_byte,
  output logic                out_out_last,
  output logic [2:0]          out_status
);
  import implode_pkg::*;

  localparam int CW = $clog2(BB + 1);

  // Configuration
  logic                 fixed_r;
  logic [23:0]          target_r;

  // Stream state
  logic [BB-1:0]        buf_r, buf_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 ended_r, ended_nxt;
  logic [1:0]           hphase_r, hphase_nxt;
  logic                 ascii_r, ascii_nxt;
  logic [2:0]           wshift_r, wshift_nxt;
  logic [HIST_AW-1:0]   wpos_r, wpos_nxt;
  logic [9:0]           cleft_r, cleft_nxt;
  logic [HIST_AW-1:0]   rpos_r, rpos_nxt;
  logic [23:0]          ocount_r, ocount_nxt;
  logic [2:0]           status_r, status_nxt;

  // Per-transaction working registers
  logic [7:0]           req_byte_r, req_byte_nxt;
  logic                 req_last_r, req_last_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  tree_t                tree_r, tree_nxt;
  logic [7:0]           wi_r, wi_nxt;
  logic [8:0]           woff_r, woff_nxt;
  logic [3:0]           wlvl_r, wlvl_nxt;
  logic [7:0]           sym_r, sym_nxt;
  logic [9:0]           len_r, len_nxt;
  logic [12:0]          dist_r, dist_nxt;
  logic                 res_taken_r, res_taken_nxt;
  logic                 res_valid_r, res_valid_nxt;
  logic [7:0]           res_byte_r, res_byte_nxt;
  logic                 res_last_r, res_last_nxt;

  // Output register
  logic                 ovalid_r, ovalid_nxt;
  logic                 otaken_r, oroom_r, ooval_r, olast_r;
  logic [7:0]           obyte_r;
  logic [2:0]           ostat_r;

  logic [7:0]           hist [4096];
  logic [7:0]           rdata_r;

  logic [BB-1:0]        sh_w;
  logic                 cur_bit;
  logic [7:0]           wc, wb, wb_prev, wsym;
  logic [8:0]           widx;
  logic                 leaf;
  logic [3:0]           n_len, n_sel;
  logic [2:0]           n_dst;
  logic [7:0]           pk, pk_mask;
  logic [9:0]           len_calc;
  logic [POS_W-1:0]     posx, need;
  logic                 bits_ok, byte_ok, room, out_free;
  logic [2:0]           ws_eff;
  logic [HIST_AW-1:0]   wmask;
  logic [12:0]          dist_calc;
  logic                 is_end, overrun, bad_dist, hdr_bad, size_reached;
  logic                 emit_en;
  logic [7:0]           emit_b;
  logic [23:0]          ocount_inc;

  assign sh_w    = buf_r >> pos_r;
  assign cur_bit = sh_w[0];

  // One level of the code tree walk per cycle.
  assign wc      = {wi_r[6:0], cur_bit};
  assign wb      = tree_branch(tree_r, wlvl_r);
  assign wb_prev = tree_branch(tree_r, wlvl_r - 4'd1);
  assign leaf    = (wc >= wb);
  assign widx    = woff_r + {1'b0, wc} - {1'b0, wb};
  assign wsym    = tree_symbol(tree_r, widx[7:0]);

  assign n_len   = (sym_r[3:0] < 4'd8) ? 4'd0 : (sym_r[3:0] - 4'd7);
  assign n_dst   = (len_r == 10'd2) ? 3'd2 : wshift_r;
  assign n_sel   = (cmd.op == S_LENX) ? n_len : {1'b0, n_dst};
  assign pk_mask = 8'((9'd1 << n_sel) - 9'd1);
  assign pk      = sh_w[7:0] & pk_mask;

  assign len_calc = (sym_r[3:0] < 4'd8) ? (10'(sym_r[3:0]) + 10'd2)
                  : (10'd8 + 10'((11'd1 << n_len)) + 10'(pk));
  assign posx     = pos_r + POS_W'(n_sel);
  assign need     = (cmd.op == S_LENX) ? posx : pos_r;
  assign bits_ok  = (CW'(need) <= cnt_r) || ended_r;
  assign byte_ok  = (cnt_r >= CW'(8)) || ended_r;
  assign room     = !ended_r && (status_r == ST_RUN)
                 && (({1'b0, cnt_r} + (CW+1)'(8)) <= (CW+1)'(BB));
  assign out_free = !ovalid_r || out_ready;

  assign ws_eff    = (wshift_r < 3'd4 || wshift_r > 3'd6) ? 3'd6 : wshift_r;
  assign wmask     = HIST_AW'((13'd1 << (4'(ws_eff) + 4'd6)) - 13'd1);
  assign dist_calc = ((13'(sym_r[5:0]) << n_dst) | 13'(pk)) + 13'd1;

  assign is_end       = (len_calc == END_LEN);
  assign overrun      = fixed_r && (({1'b0, ocount_r} + 25'(len_r)) > {1'b0, target_r});
  assign bad_dist     = (ocount_r < 24'(dist_r));
  assign hdr_bad      = (hphase_r == 2'd0) ? (buf_r[7:0] > 8'd1)
                      : (buf_r[7:0] < 8'd4 || buf_r[7:0] > 8'd6);
  assign size_reached = fixed_r && (ocount_r >= target_r);
  assign ocount_inc   = (ocount_r < COUNT_MAX) ? (ocount_r + 24'd1) : ocount_r;

  assign sts.hphase       = hphase_r;
  assign sts.byte_ok      = byte_ok;
  assign sts.hdr_bad      = hdr_bad;
  assign sts.copy_pending = (cleft_r != 10'd0);
  assign sts.size_reached = size_reached;
  assign sts.flag_bit     = buf_r[0];
  assign sts.ascii        = ascii_r;
  assign sts.leaf         = leaf;
  assign sts.is_end       = is_end;
  assign sts.bits_ok      = bits_ok;
  assign sts.overrun      = overrun;
  assign sts.bad_dist     = bad_dist;
  assign sts.stopped      = (status_r != ST_RUN);
  assign sts.out_free     = out_free;

  always_comb begin
    buf_nxt = buf_r;       cnt_nxt = cnt_r;         ended_nxt = ended_r;
    hphase_nxt = hphase_r; ascii_nxt = ascii_r;     wshift_nxt = wshift_r;
    wpos_nxt = wpos_r;     cleft_nxt = cleft_r;     rpos_nxt = rpos_r;
    ocount_nxt = ocount_r; status_nxt = status_r;
    req_byte_nxt = req_byte_r; req_last_nxt = req_last_r;
    pos_nxt = pos_r;       tree_nxt = tree_r;       wi_nxt = wi_r;
    woff_nxt = woff_r;     wlvl_nxt = wlvl_r;       sym_nxt = sym_r;
    len_nxt = len_r;       dist_nxt = dist_r;
    res_taken_nxt = res_taken_r; res_valid_nxt = res_valid_r;
    res_byte_nxt = res_byte_r;   res_last_nxt = res_last_r;
    ovalid_nxt = ovalid_r;
    emit_en = 1'b0;
    emit_b = '0;

    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;

    case (cmd.op)
      S_IDLE: begin
        if (cmd.start) begin
          req_byte_nxt = in_in_byte;
          req_last_nxt = in_in_last;
          res_taken_nxt = 1'b0;
          res_valid_nxt = 1'b0;
          res_byte_nxt = '0;
          res_last_nxt = 1'b0;
        end
      end
      S_OFFER: begin
        if (room) begin
          buf_nxt = buf_r | (BB'(req_byte_r) << cnt_r);
          cnt_nxt = cnt_r + CW'(8);
          if (req_last_r) ended_nxt = 1'b1;
          res_taken_nxt = 1'b1;
        end
      end
      S_HDR0, S_HDR1: begin
        if (((cmd.op == S_HDR0 && hphase_r == 2'd0) || (cmd.op == S_HDR1 && hphase_r == 2'd1))
            && byte_ok) begin
          buf_nxt = buf_r >> 8;
          cnt_nxt = (cnt_r < CW'(8)) ? '0 : (cnt_r - CW'(8));
          if (hphase_r == 2'd0) begin
            if (hdr_bad) status_nxt = ST_BAD_MODE;
            else begin
              ascii_nxt = buf_r[0];
              hphase_nxt = 2'd1;
            end
          end else begin
            if (hdr_bad) status_nxt = ST_BAD_DICT;
            else begin
              wshift_nxt = buf_r[2:0];
              hphase_nxt = 2'd2;
            end
          end
        end
      end
      S_DISP: begin
        if (cleft_r == 10'd0 && size_reached) begin
          status_nxt = (ocount_r == target_r) ? ST_OK : ST_SIZE;
        end
      end
      S_FLAG: begin
        wi_nxt = '0;
        woff_nxt = '0;
        wlvl_nxt = 4'd1;
        if (buf_r[0]) begin
          pos_nxt = POS_W'(1);
          tree_nxt = TR_LEN;
        end else if (ascii_r) begin
          pos_nxt = POS_W'(1);
          tree_nxt = TR_LIT;
        end else begin
          pos_nxt = POS_W'(9);
          sym_nxt = buf_r[8:1];
        end
      end
      S_LITW, S_LENW, S_DSTW: begin
        pos_nxt = pos_r + POS_W'(1);
        if (leaf) begin
          sym_nxt = wsym;
        end else begin
          woff_nxt = woff_r + {wb_prev, 1'b0} - {1'b0, wb};
          wi_nxt = wc;
          wlvl_nxt = wlvl_r + 4'd1;
        end
      end
      S_LIT: begin
        if (bits_ok) begin
          buf_nxt = buf_r >> pos_r;
          cnt_nxt = (CW'(pos_r) > cnt_r) ? '0 : (cnt_r - CW'(pos_r));
          emit_en = 1'b1;
          emit_b = sym_r;
        end
      end
      S_LENX: begin
        if (is_end) begin
          if (bits_ok) begin
            buf_nxt = buf_r >> posx;
            cnt_nxt = (CW'(posx) > cnt_r) ? '0 : (cnt_r - CW'(posx));
            status_nxt = (fixed_r && ocount_r != target_r) ? ST_SIZE : ST_OK;
          end
        end else begin
          len_nxt = len_calc;
          pos_nxt = posx;
          tree_nxt = TR_DST;
          wi_nxt = '0;
          woff_nxt = '0;
          wlvl_nxt = 4'd1;
        end
      end
      S_DSTX: begin
        dist_nxt = dist_calc;
        pos_nxt = posx;
      end
      S_CHK: begin
        if (bits_ok) begin
          buf_nxt = buf_r >> pos_r;
          cnt_nxt = (CW'(pos_r) > cnt_r) ? '0 : (cnt_r - CW'(pos_r));
          if (overrun) status_nxt = ST_OVERRUN;
          else if (bad_dist) status_nxt = ST_BAD_DIST;
          else begin
            cleft_nxt = len_r;
            rpos_nxt = HIST_AW'(13'(wpos_r) - dist_r) & wmask;
          end
        end
      end
      S_CRD: begin
      end
      S_CEM: begin
        rpos_nxt = (rpos_r + HIST_AW'(1)) & wmask;
        cleft_nxt = cleft_r - 10'd1;
        emit_en = 1'b1;
        emit_b = rdata_r;
      end
      S_RESP: begin
        if (out_free) ovalid_nxt = 1'b1;
      end
      default: begin
      end
    endcase

    if (emit_en) begin
      wpos_nxt = (wpos_r + HIST_AW'(1)) & wmask;
      ocount_nxt = ocount_inc;
      res_valid_nxt = 1'b1;
      res_byte_nxt = emit_b;
      if (fixed_r && ocount_inc == target_r) begin
        res_last_nxt = 1'b1;
        status_nxt = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_r  <= 1'b1;
      target_r <= '0;
      buf_r    <= '0;
      cnt_r    <= '0;
      ended_r  <= 1'b0;
      hphase_r <= 2'd0;
      ascii_r  <= 1'b0;
      wshift_r <= 3'd0;
      wpos_r   <= '0;
      cleft_r  <= '0;
      rpos_r   <= '0;
      ocount_r <= '0;
      status_r <= ST_RUN;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_idx == CFG_FIXED) fixed_r <= cfg_wdata[0];
      if (cfg_we && cfg_idx == CFG_TARGET) target_r <= cfg_wdata;
      buf_r    <= buf_nxt;
      cnt_r    <= cnt_nxt;
      ended_r  <= ended_nxt;
      hphase_r <= hphase_nxt;
      ascii_r  <= ascii_nxt;
      wshift_r <= wshift_nxt;
      wpos_r   <= wpos_nxt;
      cleft_r  <= cleft_nxt;
      rpos_r   <= rpos_nxt;
      ocount_r <= ocount_nxt;
      status_r <= status_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_byte_r  <= req_byte_nxt;
    req_last_r  <= req_last_nxt;
    pos_r       <= pos_nxt;
    tree_r      <= tree_nxt;
    wi_r        <= wi_nxt;
    woff_r      <= woff_nxt;
    wlvl_r      <= wlvl_nxt;
    sym_r       <= sym_nxt;
    len_r       <= len_nxt;
    dist_r      <= dist_nxt;
    res_taken_r <= res_taken_nxt;
    res_valid_r <= res_valid_nxt;
    res_byte_r  <= res_byte_nxt;
    res_last_r  <= res_last_nxt;
    if (cmd.op == S_RESP && out_free) begin
      otaken_r <= res_taken_r;
      oroom_r  <= room;
      ooval_r  <= res_valid_r;
      obyte_r  <= res_byte_r;
      olast_r  <= res_last_r;
      ostat_r  <= status_r;
    end
  end

  // History window: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (emit_en) hist[wpos_r] <= emit_b;
    if (cmd.op == S_CRD) rdata_r <= hist[rpos_r];
  end

  assign out_valid         = ovalid_r;
  assign out_byte_taken    = otaken_r;
  assign out_room_for_byte = oroom_r;
  assign out_out_valid     = ooval_r;
  assign out_out_byte      = obyte_r;
  assign out_out_last      = olast_r;
  assign out_status        = ostat_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(BB)) else $error("bit count exceeds buffer size");
  a_copy_after_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (cleft_r != 10'd0) |-> (hphase_r == 2'd2)) else $error("copy pending before header");
  a_status_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r != ST_RUN) |=> (status_r != ST_RUN)) else $error("status left final state");
  a_no_emit_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    emit_en |-> (status_r == ST_RUN)) else $error("byte emitted after stream end");
`endif

endmodule

/* hdl/implode_dcl_decompressor.sv */
`timescale 1ns / 1ps

// Streaming implode decompressor.
// Input channel (in_valid/in_ready): each transaction either offers one
// compressed byte (in_req_type 0) or asks for the next output byte (1).
// Result channel (out_valid/out_ready): exactly one result per input
// transaction, in order, held in an output register until taken.
// Configuration is a plain write port (cfg_we, cfg_idx, cfg_wdata).
// An offer is handled in S_OFFER and its result posted in S_RESP. A request
// goes straight to S_RESP once the stream has ended; otherwise its time is
// set by the code tree walker, which resolves one code bit per cycle, and
// by the registered read of the 4 KiB history memory.
// One transaction is worked on at a time; the next is accepted as soon as
// the previous result is in the output register.
// When the receiver stalls, the block finishes the current transaction and
// waits with its result until the output register frees up.
// A synchronous reset clears the stream state: header expected, empty bit
// buffer, status running. History contents are not cleared.
module implode_dcl_decompressor #(
  parameter int BIT_BUFFER_BITS = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_in_byte,
  input  logic        in_in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_byte_taken,
  output logic        out_room_for_byte,
  output logic        out_out_valid,
  output logic [7:0]  out_out_byte,
  output logic        out_out_last,
  output logic [2:0]  out_status
);
  import implode_pkg::*;

  cmd_t cmd;
  sts_t sts;

  implode_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  implode_dp #(
    .BB (BIT_BUFFER_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata),
    .in_in_byte        (in_in_byte),
    .in_in_last        (in_in_last),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte_taken    (out_byte_taken),
    .out_room_for_byte (out_room_for_byte),
    .out_out_valid     (out_out_valid),
    .out_out_byte      (out_out_byte),
    .out_out_last      (out_out_last),
    .out_status        (out_status)
  );

endmodule

/* tb/sv/implode_dcl_decompressor_test.sv */
`timescale 1ns / 1ps

module implode_dcl_decompressor_test;
  import implode_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int TREE_LIT = 0;
  localparam int TREE_LEN = 1;
  localparam int TREE_DST = 2;
  localparam int END_CODE_LEN = 519;

  typedef struct {
    bit       req;
    bit [7:0] data;
    bit       last;
  } request_t;

  typedef struct {
    bit       taken;
    bit       room;
    bit       ovalid;
    bit [7:0] obyte;
    bit       olast;
    bit [2:0] st;
  } answer_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_idx;
  logic [23:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic        in_req_type;
  logic [7:0]  in_in_byte;
  logic        in_in_last;
  logic        out_valid;
  logic        out_ready;
  logic        out_byte_taken;
  logic        out_room_for_byte;
  logic        out_out_valid;
  logic [7:0]  out_out_byte;
  logic        out_out_last;
  logic [2:0]  out_status;

  implode_dcl_decompressor dut (.*);

  request_t pending_items[$];
  answer_t  expected_answers[$];
  int       cycles;
  int       errors;
  int       results_seen;
  int       bytes_seen;
  bit       in_fire;
  int       hold_left;
  bit       hold_done;

  // Shadow state of the decompressor.
  logic [63:0] sh_buf;
  int          sh_cnt;
  bit          sh_ended;
  int          sh_hphase;
  bit          sh_ascii;
  int          sh_wshift;
  bit [7:0]    sh_hist [4096];
  int          sh_wpos;
  int          sh_cleft;
  int          sh_crpos;
  int          sh_status;
  int          sh_ocount;
  bit          sh_fixed;
  int          sh_target;
  int          sh_pos;
  answer_t     sh_ans;

  // Stream encoder state.
  bit       enc_bits[$];
  bit [7:0] enc_bytes[$];
  int       enc_count;
  int       enc_wshift;
  bit       enc_ascii;
  bit       enc_final;
  int       copies_made;

  function automatic int branch_of(int t, int lvl);
    case (t)
      TREE_LIT: return LIT_BR[lvl];
      TREE_LEN: return LEN_BR[lvl];
      default: return DST_BR[lvl];
    endcase
  endfunction

  function automatic int symbol_of(int t, int idx);
    case (t)
      TREE_LIT: return LIT_SYM[idx];
      TREE_LEN: return LEN_SYM[idx];
      default: return DST_SYM[idx];
    endcase
  endfunction

  function automatic int depth_of(int t);
    case (t)
      TREE_LIT: return 13;
      TREE_LEN: return 7;
      default: return 8;
    endcase
  endfunction

  function automatic int grab_bits(int n);
    int v;
    v = 0;
    if (sh_pos < 64) v = int'((sh_buf >> sh_pos) & ((64'd1 << n) - 1));
    sh_pos += n;
    return v;
  endfunction

  function automatic int decode_symbol(int t);
    int i, off, c, b;
    i = 0;
    off = 0;
    for (int lvl = 1; lvl <= depth_of(t); lvl++) begin
      c = 2 * i + grab_bits(1);
      b = branch_of(t, lvl);
      if (c >= b) return symbol_of(t, off + c - b);
      off += 2 * branch_of(t, lvl - 1) - b;
      i = c;
    end
    return 0;
  endfunction

  function automatic bit bits_present(int n);
    return n <= sh_cnt || sh_ended;
  endfunction

  function automatic void drop_bits(int n);
    sh_buf = sh_buf >> n;
    sh_cnt = (n > sh_cnt) ? 0 : sh_cnt - n;
  endfunction

  function automatic int window_mask();
    int s;
    s = sh_wshift;
    if (s < 4 || s > 6) s = 6;
    return ((1 << (s + 6)) - 1) & 12'hFFF;
  endfunction

  function automatic bit has_room();
    return !sh_ended && sh_status == ST_RUN && sh_cnt + 8 <= 40;
  endfunction

  function automatic void deliver(int b);
    sh_hist[sh_wpos & 12'hFFF] = b[7:0];
    sh_wpos = (sh_wpos + 1) & window_mask();
    if (sh_ocount < COUNT_MAX) sh_ocount++;
    sh_ans.ovalid = 1;
    sh_ans.obyte = b[7:0];
    if (sh_fixed && sh_ocount == sh_target) begin
      sh_ans.olast = 1;
      sh_status = ST_OK;
    end
  endfunction

  function automatic void deliver_copy();
    int b;
    b = sh_hist[sh_crpos & 12'hFFF];
    sh_crpos = (sh_crpos + 1) & window_mask();
    sh_cleft--;
    deliver(b);
  endfunction

  function automatic void decode_request();
    int v, len, span;
    sh_pos = 0;
    if (sh_hphase == 0) begin
      if (!bits_present(8)) return;
      v = int'(sh_buf[7:0]);
      drop_bits(8);
      if (v > 1) begin
        sh_status = ST_BAD_MODE;
        return;
      end
      sh_ascii = v[0];
      sh_hphase = 1;
    end
    if (sh_hphase == 1) begin
      if (!bits_present(8)) return;
      v = int'(sh_buf[7:0]);
      drop_bits(8);
      if (v < 4 || v > 6) begin
        sh_status = ST_BAD_DICT;
        return;
      end
      sh_wshift = v;
      sh_hphase = 2;
    end
    if (sh_cleft != 0) begin
      deliver_copy();
      return;
    end
    if (sh_fixed && sh_ocount >= sh_target) begin
      sh_status = (sh_ocount == sh_target) ? ST_OK : ST_SIZE;
      return;
    end
    if (grab_bits(1) == 0) begin
      v = sh_ascii ? decode_symbol(TREE_LIT) : grab_bits(8);
      if (!bits_present(sh_pos)) return;
      drop_bits(sh_pos);
      deliver(v);
      return;
    end
    v = decode_symbol(TREE_LEN);
    len = (v < 8) ? v + 2 : 8 + (1 << (v - 7)) + grab_bits(v - 7);
    if (len == END_CODE_LEN) begin
      if (!bits_present(sh_pos)) return;
      drop_bits(sh_pos);
      sh_status = (sh_fixed && sh_ocount != sh_target) ? ST_SIZE : ST_OK;
      return;
    end
    v = decode_symbol(TREE_DST);
    if (len == 2) span = (v << 2) | grab_bits(2);
    else span = (v << sh_wshift) | grab_bits(sh_wshift);
    span++;
    if (!bits_present(sh_pos)) return;
    drop_bits(sh_pos);
    if (sh_fixed && sh_ocount + len > sh_target) begin
      sh_status = ST_OVERRUN;
      return;
    end
    if (sh_ocount < span) begin
      sh_status = ST_BAD_DIST;
      return;
    end
    sh_cleft = len;
    sh_crpos = (sh_wpos - span) & window_mask();
    deliver_copy();
  endfunction

  function automatic void predict_answer(request_t it);
    sh_ans = '{default: 0};
    if (!it.req) begin
      if (has_room()) begin
        sh_buf = sh_buf | (64'(it.data) << sh_cnt);
        sh_cnt += 8;
        if (it.last) sh_ended = 1;
        sh_ans.taken = 1;
      end
    end else if (sh_status == ST_RUN) begin
      decode_request();
    end
    sh_ans.room = has_room();
    sh_ans.st = sh_status[2:0];
  endfunction

  // Encoder: bits go out LSB first; tree codes go out in reading order.
  function automatic void put_bits(int v, int n);
    for (int k = 0; k < n; k++) enc_bits.push_back(v[k]);
    while (enc_bits.size() >= 8) begin
      bit [7:0] b;
      for (int k = 0; k < 8; k++) b[k] = enc_bits.pop_front();
      enc_bytes.push_back(b);
    end
  endfunction

  function automatic void put_symbol(int t, int s);
    int off, b;
    off = 0;
    for (int lvl = 1; lvl <= depth_of(t); lvl++) begin
      b = branch_of(t, lvl);
      for (int c = b; c < 2 * branch_of(t, lvl - 1); c++)
        if (symbol_of(t, off + c - b) == s) begin
          for (int k = lvl - 1; k >= 0; k--) put_bits(c >> k, 1);
          return;
        end
      off += 2 * branch_of(t, lvl - 1) - b;
    end
  endfunction

  function automatic void put_literal(int v);
    put_bits(0, 1);
    if (enc_ascii) put_symbol(TREE_LIT, v);
    else put_bits(v, 8);
    enc_count++;
  endfunction

  function automatic void put_length(int len);
    int nb;
    put_bits(1, 1);
    if (len < 10) begin
      put_symbol(TREE_LEN, len - 2);
    end else begin
      nb = 1;
      while ((1 << (nb + 1)) <= len - 8) nb++;
      put_symbol(TREE_LEN, nb + 7);
      put_bits(len - 8 - (1 << nb), nb);
    end
  endfunction

  function automatic void put_copy(int len, int back);
    int dd;
    dd = back - 1;
    put_length(len);
    if (len == 2) begin
      put_symbol(TREE_DST, dd >> 2);
      put_bits(dd, 2);
    end else begin
      put_symbol(TREE_DST, dd >> enc_wshift);
      put_bits(dd, enc_wshift);
    end
    enc_count += len;
    copies_made++;
  endfunction

  function automatic void put_random_token();
    int maxd, len, r;
    if (enc_count == 0 || $urandom_range(0, 99) < 55) begin
      put_literal($urandom_range(0, 255));
      return;
    end
    r = $urandom_range(0, 99);
    len = (r < 80) ? $urandom_range(2, 12) :
          (r < 95) ? $urandom_range(13, 100) : $urandom_range(101, 518);
    maxd = (enc_count < (64 << enc_wshift)) ? enc_count : (64 << enc_wshift);
    if (len == 2 && maxd > 256) maxd = 256;
    if ($urandom_range(0, 1)) put_copy(len, $urandom_range(1, (maxd < 8) ? maxd : 8));
    else put_copy(len, $urandom_range(1, maxd));
  endfunction

  function automatic void close_stream();
    while (enc_bits.size() != 0) put_bits(0, 1);
    enc_final = 1;
  endfunction

  function automatic void queue_item(request_t it);
    predict_answer(it);
    expected_answers.push_back(sh_ans);
    pending_items.push_back(it);
  endfunction

  // Offers the next stream byte or asks for output; now and then offers into a
  // full buffer so that a refusal is seen and the byte offered again later.
  function automatic void queue_next(bit force_offer);
    request_t it;
    int r;
    r = $urandom_range(0, 99);
    if (enc_bytes.size() != 0 && (force_offer || (has_room() && r < 50) || r < 4)) begin
      it.req = 0;
      it.data = enc_bytes[0];
      it.last = enc_final && enc_bytes.size() == 1;
      queue_item(it);
      if (sh_ans.taken) void'(enc_bytes.pop_front());
    end else begin
      it.req = 1;
      it.data = $urandom_range(0, 255);
      it.last = $urandom_range(0, 1);
      queue_item(it);
    end
  endfunction

  function automatic void queue_random(int n);
    for (int k = 0; k < n; k++) begin
      if (enc_bytes.size() < 3) put_random_token();
      queue_next(0);
    end
  endfunction

  task automatic write_reg(logic idx, logic [23:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    if (idx == CFG_FIXED) sh_fixed = value[0];
    else sh_target = int'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_answers.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    answer_t want;
    in_fire = in_valid && in_ready;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("implode_dcl_decompressor verification failed");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_out_valid) bytes_seen++;
      if (expected_answers.size() == 0) begin
        $display("%0t: result with nothing expected, status %0d", $time, out_status);
        errors++;
      end else begin
        want = expected_answers.pop_front();
        check_field("byte_taken", want.taken, out_byte_taken);
        check_field("room_for_byte", want.room, out_room_for_byte);
        check_field("out_valid", want.ovalid, out_out_valid);
        check_field("out_byte", want.obyte, out_out_byte);
        check_field("out_last", want.olast, out_out_last);
        check_field("status", want.st, out_status);
      end
    end
  end

  // Sender: holds a transaction until it is accepted, idles at random outside
  // the quiet stretch.
  always @(negedge clk) begin
    request_t it;
    bit quiet;
    quiet = cycles > 2000 && cycles < 6000;
    if (rst_n && !(in_valid && !in_fire)) begin
      if (pending_items.size() != 0 && (quiet || $urandom_range(0, 99) >= 34)) begin
        it = pending_items.pop_front();
        in_valid <= 1'b1;
        in_req_type <= it.req;
        in_in_byte <= it.data;
        in_in_last <= it.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: one long hold-off so the block backs up into its input.
  always @(negedge clk) begin
    bit quiet;
    quiet = cycles > 2000 && cycles < 6000;
    if (!hold_done && results_seen >= 800) begin
      hold_done <= 1'b1;
      hold_left <= 600;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || $urandom_range(0, 99) >= 34;
    end
  end

  initial begin
    request_t it;
    int ending, guard;
    string ending_name;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_FIXED;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_req_type = 1'b0;
    in_in_byte = '0;
    in_in_last = 1'b0;
    out_ready = 1'b0;
    cycles = 0;
    errors = 0;
    hold_left = 0;
    hold_done = 0;
    in_fire = 0;
    sh_buf = '0;
    sh_cnt = 0;
    sh_ended = 0;
    sh_hphase = 0;
    sh_ascii = 0;
    sh_wshift = 0;
    sh_wpos = 0;
    sh_cleft = 0;
    sh_crpos = 0;
    sh_status = ST_RUN;
    sh_ocount = 0;
    sh_fixed = 1;
    sh_target = 0;
    enc_count = 0;
    enc_final = 0;
    copies_made = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    write_reg(CFG_FIXED, 24'd1);
    write_reg(CFG_TARGET, 24'd0);
    write_reg(CFG_FIXED, 24'd0);

    // Directed start: header, extreme literals, overlapping copies, and a
    // buffer filled until an offer is refused.
    enc_ascii = $urandom_range(0, 1);
    enc_wshift = $urandom_range(4, 6);
    put_bits(enc_ascii, 8);
    put_bits(enc_wshift, 8);
    put_literal(0);
    put_literal(255);
    put_literal($urandom_range(0, 255));
    put_copy(3, 1);
    put_copy(2, 3);
    put_copy(10, 2);
    for (int k = 0; k < 6; k++) queue_next(1);
    for (int k = 0; k < 18; k++) begin
      it.req = 1;
      it.data = $urandom_range(0, 255);
      it.last = $urandom_range(0, 1);
      queue_item(it);
    end
    wait_drained();

    write_reg(CFG_TARGET, 24'hFFFFFF);
    write_reg(CFG_FIXED, 24'd1);
    queue_random(950);
    wait_drained();

    write_reg(CFG_FIXED, 24'd0);
    queue_random(950);
    wait_drained();

    ending = $urandom_range(0, 3);
    case (ending)
      0: begin
        ending_name = "end code";
        put_length(END_CODE_LEN);
      end
      1: begin
        ending_name = "fixed size reached";
        write_reg(CFG_FIXED, 24'd1);
        write_reg(CFG_TARGET, 24'(enc_count + 5));
        for (int k = 0; k < 5; k++) put_literal($urandom_range(0, 255));
      end
      2: begin
        ending_name = "size mismatch";
        write_reg(CFG_FIXED, 24'd1);
        write_reg(CFG_TARGET, 24'hFFFFFF);
        put_length(END_CODE_LEN);
      end
      default: begin
        ending_name = "overrun";
        write_reg(CFG_FIXED, 24'd1);
        write_reg(CFG_TARGET, 24'(enc_count + 1));
        put_copy(5, 1);
      end
    endcase
    close_stream();
    guard = 0;
    while ((sh_status == ST_RUN || enc_bytes.size() != 0) && guard < 20000) begin
      queue_next(0);
      guard++;
    end
    // After the end, offers are refused and requests change nothing.
    for (int k = 0; k < 8; k++) begin
      it.req = k[0];
      it.data = $urandom_range(0, 255);
      it.last = 1;
      queue_item(it);
    end
    wait_drained();

    $display("Stream of %0d output bytes with %0d copies, %s literals, window shift %0d.",
             enc_count, copies_made, enc_ascii ? "coded" : "raw", enc_wshift);
    $display("Checked %0d results, %0d carrying data; stream ended by %s.",
             results_seen, bytes_seen, ending_name);
    if (errors == 0) begin
      $display("implode_dcl_decompressor verification clean");
    end else begin
      $display("implode_dcl_decompressor verification failed");
    end
    $finish;
  end

endmodule
